FILE: sv/u16550_pkg.sv
package u16550_pkg;

    // Receive store geometry
    localparam int FIFO_DEPTH = 16;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Item kinds
    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_RX    = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    // Register offsets
    localparam logic [2:0] OFF_RBR = 3'd0;
    localparam logic [2:0] OFF_IER = 3'd1;
    localparam logic [2:0] OFF_IIR = 3'd2;
    localparam logic [2:0] OFF_LCR = 3'd3;
    localparam logic [2:0] OFF_MCR = 3'd4;
    localparam logic [2:0] OFF_LSR = 3'd5;
    localparam logic [2:0] OFF_MSR = 3'd6;
    localparam logic [2:0] OFF_SCR = 3'd7;

    // Interrupt identification codes
    localparam logic [3:0] IIR_TIMEOUT = 4'hC;
    localparam logic [3:0] IIR_RDA     = 4'h4;
    localparam logic [3:0] IIR_THRE    = 4'h2;
    localparam logic [3:0] IIR_NONE    = 4'h1;

    // Register constants
    localparam logic [7:0] DLL_RESET     = 8'h0C;
    localparam logic [7:0] FCR_MASK      = 8'hC9;
    localparam logic [7:0] MSR_IDLE      = 8'hB0;
    localparam logic [7:0] IIR_FIFO_BITS = 8'hC0;
    localparam logic [7:0] LSR_BASE      = 8'h60;

    // Received-data trigger level from FCR bits 7:6
    function automatic logic [CNT_W-1:0] trig_level(input logic [1:0] sel);
        logic [CNT_W-1:0] lvl;
        case (sel)
            2'd0:    lvl = CNT_W'(1);
            2'd1:    lvl = CNT_W'(4);
            2'd2:    lvl = CNT_W'(8);
            default: lvl = CNT_W'(14);
        endcase
        return lvl;
    endfunction

    // Highest-priority pending interrupt cause
    function automatic logic [3:0] cause_id(input logic [3:0]       ier,
                                            input logic [7:0]       fcr,
                                            input logic [CNT_W-1:0] count,
                                            input logic             thre);
        logic [3:0]       id;
        logic [CNT_W-1:0] trig;
        trig = fcr[0] ? trig_level(fcr[7:6]) : CNT_W'(1);
        if (ier[0] && (count != '0))
            id = (fcr[0] && (count < trig)) ? IIR_TIMEOUT : IIR_RDA;
        else if (ier[1] && thre)
            id = IIR_THRE;
        else
            id = IIR_NONE;
        return id;
    endfunction

endpackage

FILE: sv/u16550_if.sv
interface u16550_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [2:0] reg_offset;
    logic [7:0] write_data;
    logic [7:0] rx_byte;

    modport source (output valid, output func, output reg_offset, output write_data,
                    output rx_byte, input ready);
    modport sink   (input valid, input func, input reg_offset, input write_data,
                    input rx_byte, output ready);
endinterface

interface u16550_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       irq_level;
    logic       irq_retrigger;

    modport source (output valid, output read_data, output tx_valid, output tx_byte,
                    output irq_level, output irq_retrigger, input ready);
    modport sink   (input valid, input read_data, input tx_valid, input tx_byte,
                    input irq_level, input irq_retrigger, output ready);
endinterface

FILE: sv/u16550_ram.sv
module u16550_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/uart_16550_register_model_top.sv
// 16550A-style UART register file with instant transmission.
//
// Channels: req carries one item per transfer (register read, register
// write or a byte received from the far end); rsp returns exactly one
// result per item, in order: read data, an outgoing byte when a THR write
// transmits, the interrupt line level and a retrigger pulse.
//
// Between the req transfer and rsp valid an item passes the RAM-read stage,
// which updates the register file and issues the receive-store read, then
// the output register, which captures the store's registered read data.
// Throughput is one item per cycle while rsp does not stall, set by the
// single read/modify/write pass over the control registers and the
// registered read of the receive-store RAM.
//
// Reset clears all control registers (divisor latch to 0x0C), empties the
// receive FIFO and drops the interrupt line; no clearing pass is needed.
// When rsp stalls, the output register holds its result, one more item
// waits in the RAM-read stage, and req.ready drops until rsp moves again.
module uart_16550_register_model_top (
    input  logic        clk,
    input  logic        rst_n,
    u16550_req_if.sink  req,
    u16550_rsp_if.source rsp
);

    localparam int PTR_W = u16550_pkg::PTR_W;
    localparam int CNT_W = u16550_pkg::CNT_W;

    // Control state
    logic [3:0]       ier_reg, ier_next;
    logic [7:0]       lcr_reg, lcr_next;
    logic [4:0]       mcr_reg, mcr_next;
    logic [7:0]       scr_reg, scr_next;
    logic [7:0]       fcr_reg, fcr_next;
    logic [7:0]       dll_reg, dll_next;
    logic [7:0]       dlm_reg, dlm_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             thre_reg, thre_next;
    logic             line_reg, line_next;
    logic [3:0]       last_reg, last_next;

    // RAM-read stage and output stage
    logic             s1_valid_reg;
    logic             s1_use_ram_reg;
    logic [7:0]       s1_rd_reg;
    logic             s1_txv_reg;
    logic [7:0]       s1_txb_reg;
    logic             s1_level_reg;
    logic             s1_pulse_reg;

    logic             out_valid_reg;
    logic [7:0]       out_rd_reg;
    logic             out_txv_reg;
    logic [7:0]       out_txb_reg;
    logic             out_level_reg;
    logic             out_pulse_reg;

    logic             s1_adv;
    logic             acc;
    u16550_pkg::func_t fn;
    logic             dlab;
    logic             loop_mode;

    logic [7:0]       rd;
    logic             use_ram;
    logic             pop;
    logic             txv;
    logic [7:0]       txb;
    logic             pulse;
    logic             push;
    logic [7:0]       push_byte;
    logic             refresh;
    logic [3:0]       cause_cur;
    logic [3:0]       cause_new;
    logic             level;
    logic [CNT_W-1:0] capacity;

    logic             ram_we;
    logic [PTR_W-1:0] ram_waddr;
    logic [7:0]       ram_rdata;

    // Handshake: output register parts the two sides
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_adv;
    assign acc       = req.valid && req.ready;

    assign fn        = u16550_pkg::func_t'(req.func);
    assign dlab      = lcr_reg[7];
    assign loop_mode = mcr_reg[4];
    assign capacity  = fcr_reg[0] ? CNT_W'(u16550_pkg::FIFO_DEPTH) : CNT_W'(1);
    assign cause_cur = u16550_pkg::cause_id(ier_reg, fcr_reg, count_reg, thre_reg);

    // Register file update for the accepted item
    always_comb
    begin
        ier_next   = ier_reg;
        lcr_next   = lcr_reg;
        mcr_next   = mcr_reg;
        scr_next   = scr_reg;
        fcr_next   = fcr_reg;
        dll_next   = dll_reg;
        dlm_next   = dlm_reg;
        head_next  = head_reg;
        count_next = count_reg;
        thre_next  = thre_reg;
        line_next  = line_reg;
        last_next  = last_reg;
        rd         = '0;
        use_ram    = 1'b0;
        pop        = 1'b0;
        txv        = 1'b0;
        txb        = '0;
        pulse      = 1'b0;
        push       = 1'b0;
        push_byte  = '0;
        refresh    = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = head_reg + count_reg[PTR_W-1:0];
        cause_new  = u16550_pkg::IIR_NONE;
        level      = 1'b0;

        if (acc)
        begin
            case (fn)
                u16550_pkg::FUNC_READ:
                begin
                    refresh = 1'b1;
                    case (req.reg_offset)
                        u16550_pkg::OFF_RBR:
                        begin
                            if (dlab)
                            begin
                                rd = dll_reg;
                            end
                            else if (count_reg != '0)
                            begin
                                use_ram    = 1'b1;
                                pop        = 1'b1;
                                head_next  = head_reg + PTR_W'(1);
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        u16550_pkg::OFF_IER: rd = dlab ? dlm_reg : {4'b0, ier_reg};
                        u16550_pkg::OFF_IIR:
                        begin
                            rd = {4'b0, cause_cur}
                               | (fcr_reg[0] ? u16550_pkg::IIR_FIFO_BITS : 8'h00);
                            if (cause_cur == u16550_pkg::IIR_THRE)
                            begin
                                thre_next = 1'b0;
                            end
                        end
                        u16550_pkg::OFF_LCR: rd = lcr_reg;
                        u16550_pkg::OFF_MCR: rd = {3'b0, mcr_reg};
                        u16550_pkg::OFF_LSR:
                            rd = u16550_pkg::LSR_BASE | {7'b0, (count_reg != '0)};
                        u16550_pkg::OFF_MSR:
                            rd = loop_mode ? {mcr_reg[3], mcr_reg[2], mcr_reg[0], mcr_reg[1], 4'b0}
                                           : u16550_pkg::MSR_IDLE;
                        default: rd = scr_reg;
                    endcase
                end
                u16550_pkg::FUNC_WRITE:
                begin
                    refresh = 1'b1;
                    case (req.reg_offset)
                        u16550_pkg::OFF_RBR:
                        begin
                            if (dlab)
                            begin
                                dll_next = req.write_data;
                            end
                            else
                            begin
                                if (loop_mode)
                                begin
                                    push      = 1'b1;
                                    push_byte = req.write_data;
                                end
                                else
                                begin
                                    txv = 1'b1;
                                    txb = req.write_data;
                                end
                                thre_next = 1'b1;
                            end
                        end
                        u16550_pkg::OFF_IER:
                        begin
                            if (dlab)
                            begin
                                dlm_next = req.write_data;
                            end
                            else
                            begin
                                if (req.write_data[1])
                                begin
                                    thre_next = 1'b1;
                                end
                                ier_next = req.write_data[3:0];
                            end
                        end
                        u16550_pkg::OFF_IIR:
                        begin
                            if ((req.write_data[0] ^ fcr_reg[0]) || req.write_data[1])
                            begin
                                head_next  = '0;
                                count_next = '0;
                            end
                            fcr_next = req.write_data & u16550_pkg::FCR_MASK;
                        end
                        u16550_pkg::OFF_LCR: lcr_next = req.write_data;
                        u16550_pkg::OFF_MCR: mcr_next = req.write_data[4:0];
                        u16550_pkg::OFF_SCR: scr_next = req.write_data;
                        default: ;
                    endcase
                end
                u16550_pkg::FUNC_RX:
                begin
                    refresh = 1'b1;
                    if (!loop_mode)
                    begin
                        push      = 1'b1;
                        push_byte = req.rx_byte;
                    end
                end
                default: ;
            endcase

            // Queue into the receive store; drop on overrun
            if (push && (count_reg < capacity))
            begin
                ram_we     = 1'b1;
                count_next = count_reg + CNT_W'(1);
            end

            // Re-evaluate the interrupt line on the updated state
            if (refresh)
            begin
                cause_new = u16550_pkg::cause_id(ier_next, fcr_next, count_next, thre_next);
                level     = (cause_new != u16550_pkg::IIR_NONE);
                if (level && line_reg && (cause_new != last_reg))
                begin
                    pulse = 1'b1;
                end
                else if (level != line_reg)
                begin
                    line_next = level;
                end
                last_next = cause_new;
            end
        end
    end

    // Receive store
    u16550_ram #(
        .WIDTH (8),
        .DEPTH (u16550_pkg::FIFO_DEPTH)
    ) u_rx_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (push_byte),
        .re    (acc),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ier_reg       <= '0;
            lcr_reg       <= '0;
            mcr_reg       <= '0;
            scr_reg       <= '0;
            fcr_reg       <= '0;
            dll_reg       <= u16550_pkg::DLL_RESET;
            dlm_reg       <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            thre_reg      <= 1'b0;
            line_reg      <= 1'b0;
            last_reg      <= u16550_pkg::IIR_NONE;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ier_reg   <= ier_next;
            lcr_reg   <= lcr_next;
            mcr_reg   <= mcr_next;
            scr_reg   <= scr_next;
            fcr_reg   <= fcr_next;
            dll_reg   <= dll_next;
            dlm_reg   <= dlm_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            thre_reg  <= thre_next;
            line_reg  <= line_next;
            last_reg  <= last_next;

            if (acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Advance payload through the RAM-read and output stages
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_use_ram_reg <= use_ram;
            s1_rd_reg      <= rd;
            s1_txv_reg     <= txv;
            s1_txb_reg     <= txb;
            s1_level_reg   <= line_next;
            s1_pulse_reg   <= pulse;
        end
        if (s1_adv)
        begin
            out_rd_reg    <= s1_use_ram_reg ? ram_rdata : s1_rd_reg;
            out_txv_reg   <= s1_txv_reg;
            out_txb_reg   <= s1_txb_reg;
            out_level_reg <= s1_level_reg;
            out_pulse_reg <= s1_pulse_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.read_data     = out_rd_reg;
    assign rsp.tx_valid      = out_txv_reg;
    assign rsp.tx_byte       = out_txb_reg;
    assign rsp.irq_level     = out_level_reg;
    assign rsp.irq_retrigger = out_pulse_reg;

    // Fill count never exceeds the store
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(u16550_pkg::FIFO_DEPTH))
        else $error("receive count beyond store depth");

    // Without FIFO mode the store holds one byte at most
    a_count_single: assert property (@(posedge clk) disable iff (!rst_n)
        !fcr_reg[0] |-> (count_reg <= CNT_W'(1)))
        else $error("receive count above one with FIFO off");

    // A retrigger pulse only occurs while the line stays up
    a_pulse_level: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && pulse) |-> line_next)
        else $error("retrigger without interrupt line");

    // An RBR pop removes exactly one byte
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && pop) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("RBR read did not drop one byte");

    // A stalled RAM-read stage keeps the input side closed
    a_stall_block: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !rsp.ready) |-> !req.ready)
        else $error("input taken while both stages are full");

endmodule
